@@ rtl/spq_pkg.sv @@
// shared types, constants and field widths for the shared pair queue
`timescale 1ns / 1ps
package spq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int MAX_PLAYERS_DEF = 8;

	localparam int PLAYER_W = 3;
	localparam int RAND_W   = 15;
	localparam int COLOUR_W = 3;
	localparam int PCOUNT_W = 4;
	localparam int CFG_W    = 4;
	localparam int NEFF_W   = PCOUNT_W + 1;

	localparam logic [COLOUR_W-1:0] COLOUR_MAX = COLOUR_W'(6);

	// remainder unit takes this many raw bits per cycle
	localparam int MOD_DIGIT = 3;
	localparam int MOD_STEPS = RAND_W / MOD_DIGIT;
	localparam int MOD_CNT_W = $clog2(MOD_STEPS + 1);

	localparam logic REG_PLAYER_COUNT = 1'b0;
	localparam logic REG_COLOUR_COUNT = 1'b1;

	localparam logic OP_FETCH = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_MOD,
		ST_READ,
		ST_SCAN,
		ST_DROP,
		ST_DONE
	} spq_state_t;

endpackage

@@ rtl/spq_colour_mod.sv @@
// iterative remainder unit reducing two raw random values by the colour count
`timescale 1ns / 1ps
module spq_colour_mod (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [spq_pkg::COLOUR_W-1:0]  divisor,
	input  logic [spq_pkg::RAND_W-1:0]    raw_a,
	input  logic [spq_pkg::RAND_W-1:0]    raw_b,
	output logic                          done,
	output logic [spq_pkg::COLOUR_W-1:0]  rem_a,
	output logic [spq_pkg::COLOUR_W-1:0]  rem_b
);
	import spq_pkg::*;

	logic [RAND_W-1:0]    a_q, b_q;
	logic [COLOUR_W-1:0]  ra_q, rb_q;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic                 done_q;

	// restoring remainder over one digit, msb first
	function automatic logic [COLOUR_W-1:0] mod_step(
		input logic [COLOUR_W-1:0]  r,
		input logic [MOD_DIGIT-1:0] bits,
		input logic [COLOUR_W-1:0]  d
	);
		logic [COLOUR_W:0]   t;
		logic [COLOUR_W-1:0] acc;
		acc = r;
		for (int k = MOD_DIGIT - 1; k >= 0; k--) begin
			t = {acc, bits[k]};
			if (t >= {1'b0, d}) begin
				t = t - {1'b0, d};
			end
			acc = t[COLOUR_W-1:0];
		end
		return acc;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= MOD_CNT_W'(MOD_STEPS);
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == MOD_CNT_W'(1));
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - MOD_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= raw_a;
			b_q  <= raw_b;
			ra_q <= '0;
			rb_q <= '0;
		end else if (cnt_q != '0) begin
			ra_q <= mod_step(ra_q, a_q[RAND_W-1 -: MOD_DIGIT], divisor);
			rb_q <= mod_step(rb_q, b_q[RAND_W-1 -: MOD_DIGIT], divisor);
			a_q  <= {a_q[RAND_W-MOD_DIGIT-1:0], {MOD_DIGIT{1'b0}}};
			b_q  <= {b_q[RAND_W-MOD_DIGIT-1:0], {MOD_DIGIT{1'b0}}};
		end
	end

	assign done  = done_q;
	assign rem_a = ra_q;
	assign rem_b = rb_q;

endmodule

@@ rtl/spq_pair_ram.sv @@
// pair store memory, one write and one registered read port
`timescale 1ns / 1ps
module spq_pair_ram #(
	parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
	localparam int IDX_W = $clog2(QUEUE_DEPTH)
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [IDX_W-1:0]                waddr,
	input  logic [2*spq_pkg::COLOUR_W-1:0]  wdata,
	input  logic                            re,
	input  logic [IDX_W-1:0]                raddr,
	output logic [2*spq_pkg::COLOUR_W-1:0]  rdata
);
	import spq_pkg::*;

	logic [2*COLOUR_W-1:0] mem [QUEUE_DEPTH];
	logic [2*COLOUR_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/shared_pair_queue_multi_reader.sv @@
// top level: shared pair queue with per-player read offsets
//
// input channel (in_valid / in_stall) carries one request: a fetch for a
// player or a clear. every request gives exactly one result transaction on
// the output channel (out_valid / out_stall). requests are served one at a
// time; in_stall is high from acceptance until the result is loaded into
// the output register.
// a fetch steps through lookup, read, the offset scan, drop and done;
// the scan finds the minimum, one offset per cycle. when a new pair must
// be appended the remainder unit runs between lookup and read (three
// raw bits per cycle over five steps, both colours side by side). a
// clear, an out-of-range player or a refused fetch goes from lookup
// straight to done. the output register holds its result while out_stall
// is high; the next request is taken meanwhile and waits in its last
// step for the slot. configuration (cfg_write, cfg_index, cfg_data) is
// to be written by the user only while idle; the block does not enforce
// it. reset empties the queue, zeroes all offsets and sets player count
// 2 and colour count 4; the pair store needs no clearing pass.
`timescale 1ns / 1ps
module shared_pair_queue_multi_reader #(
	parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEF,
	parameter int MAX_PLAYERS = spq_pkg::MAX_PLAYERS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic                          cfg_index,
	input  logic [spq_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          operation,
	input  logic [spq_pkg::PLAYER_W-1:0]  player,
	input  logic [spq_pkg::RAND_W-1:0]    random_first,
	input  logic [spq_pkg::RAND_W-1:0]    random_second,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [spq_pkg::COLOUR_W-1:0]  first_colour,
	output logic [spq_pkg::COLOUR_W-1:0]  second_colour,
	output logic                          appended,
	output logic                          refused
);
	import spq_pkg::*;

	localparam int IDX_W  = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int PIDX_W = (MAX_PLAYERS > 1) ? $clog2(MAX_PLAYERS) : 1;

	spq_state_t state_q, state_d;

	logic [PCOUNT_W-1:0] player_count_q;
	logic [COLOUR_W-1:0] colour_count_q;

	logic [CNT_W-1:0]  offs_q [MAX_PLAYERS];
	logic [IDX_W-1:0]  head_q;
	logic [CNT_W-1:0]  count_q;

	logic              op_q;
	logic              who_ok_q;
	logic [PIDX_W-1:0] who_q;
	logic [RAND_W-1:0] rand_a_q, rand_b_q;
	logic [CNT_W-1:0]  off_q;
	logic [CNT_W-1:0]  mn_q;
	logic [NEFF_W-1:0] scan_q;

	logic [COLOUR_W-1:0] res_first_q, res_second_q;
	logic                res_app_q, res_ref_q;

	logic                out_valid_q;
	logic [COLOUR_W-1:0] out_first_q, out_second_q;
	logic                out_app_q, out_ref_q;

	logic [NEFF_W-1:0]   n_eff;
	logic [COLOUR_W-1:0] divisor;
	logic [PIDX_W-1:0]   rd_idx;
	logic [CNT_W-1:0]    rd_off;
	logic [CNT_W-1:0]    off_c;
	logic [CNT_W-1:0]    mn_c;
	logic [PIDX_W+PLAYER_W-1:0] who_ext;

	logic                  mod_start, mod_done;
	logic [COLOUR_W-1:0]   rem_a, rem_b;
	logic                  ram_we, ram_re;
	logic [IDX_W-1:0]      ram_waddr, ram_raddr;
	logic [2*COLOUR_W-1:0] ram_rdata;
	logic                  out_free;
	logic                  accept;

	function automatic logic [IDX_W-1:0] wrap_add(
		input logic [IDX_W-1:0] a,
		input logic [CNT_W-1:0] b
	);
		logic [CNT_W:0] s;
		s = {{(CNT_W + 1 - IDX_W){1'b0}}, a} + {1'b0, b};
		if (s >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
			s = s - (CNT_W + 1)'(QUEUE_DEPTH);
		end
		return s[IDX_W-1:0];
	endfunction

	// effective counts after clamping out-of-range register values
	always_comb begin
		if (player_count_q == '0) begin
			n_eff = NEFF_W'(1);
		end else if ({1'b0, player_count_q} > NEFF_W'(MAX_PLAYERS)) begin
			n_eff = NEFF_W'(MAX_PLAYERS);
		end else begin
			n_eff = {1'b0, player_count_q};
		end
		if (colour_count_q == '0) begin
			divisor = COLOUR_W'(1);
		end else if (colour_count_q > COLOUR_MAX) begin
			divisor = COLOUR_MAX;
		end else begin
			divisor = colour_count_q;
		end
	end

	assign who_ext = {{PIDX_W{1'b0}}, player};

	// single offset read port: requester during lookup, scan index otherwise
	assign rd_idx = (state_q == ST_LOOKUP) ? who_q : scan_q[PIDX_W-1:0];
	assign rd_off = offs_q[rd_idx];
	assign off_c  = (rd_off > count_q) ? count_q : rd_off;
	assign mn_c   = (mn_q > count_q) ? count_q : mn_q;

	assign ram_waddr = wrap_add(head_q, count_q);
	assign ram_raddr = wrap_add(head_q, off_q);
	assign out_free  = !out_valid_q || !out_stall;
	assign accept    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		mod_start = 1'b0;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (op_q == OP_CLEAR || !who_ok_q) begin
					state_d = ST_DONE;
				end else if (off_c == count_q) begin
					if (count_q == CNT_W'(QUEUE_DEPTH)) begin
						state_d = ST_DONE;
					end else begin
						mod_start = 1'b1;
						state_d   = ST_MOD;
					end
				end else begin
					state_d = ST_READ;
				end
			end
			ST_MOD: begin
				if (mod_done) begin
					ram_we  = 1'b1;
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				ram_re  = 1'b1;
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_q == n_eff - NEFF_W'(1)) begin
					state_d = ST_DROP;
				end
			end
			ST_DROP: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// configuration and queue control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			player_count_q <= PCOUNT_W'(2);
			colour_count_q <= COLOUR_W'(4);
			head_q         <= '0;
			count_q        <= '0;
			for (int i = 0; i < MAX_PLAYERS; i++) begin
				offs_q[i] <= '0;
			end
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					REG_PLAYER_COUNT: player_count_q <= cfg_data;
					REG_COLOUR_COUNT: colour_count_q <= cfg_data[COLOUR_W-1:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_LOOKUP: begin
					if (op_q == OP_CLEAR) begin
						head_q  <= '0;
						count_q <= '0;
						for (int i = 0; i < MAX_PLAYERS; i++) begin
							offs_q[i] <= '0;
						end
					end
				end
				ST_MOD: begin
					if (mod_done) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				ST_READ: begin
					offs_q[who_q] <= off_q + CNT_W'(1);
				end
				ST_DROP: begin
					// inactive players saturate at zero
					for (int i = 0; i < MAX_PLAYERS; i++) begin
						offs_q[i] <= (offs_q[i] > mn_c) ? offs_q[i] - mn_c : '0;
					end
					head_q  <= wrap_add(head_q, mn_c);
					count_q <= count_q - mn_c;
				end
				default: ;
			endcase
		end
	end

	// per-transaction working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q     <= operation;
					who_ok_q <= ({{(NEFF_W - PLAYER_W){1'b0}}, player} < n_eff);
					who_q    <= who_ext[PIDX_W-1:0];
					rand_a_q <= random_first;
					rand_b_q <= random_second;
				end
				res_first_q  <= '0;
				res_second_q <= '0;
				res_app_q    <= 1'b0;
				res_ref_q    <= 1'b0;
			end
			ST_LOOKUP: begin
				off_q <= off_c;
				if (op_q == OP_FETCH && who_ok_q && off_c == count_q &&
				    count_q == CNT_W'(QUEUE_DEPTH)) begin
					res_ref_q <= 1'b1;
				end
			end
			ST_MOD: begin
				if (mod_done) begin
					res_app_q <= 1'b1;
				end
			end
			ST_READ: begin
				scan_q <= '0;
			end
			ST_SCAN: begin
				if (scan_q == '0 || rd_off < mn_q) begin
					mn_q <= rd_off;
				end
				scan_q <= scan_q + NEFF_W'(1);
			end
			ST_DROP: begin
				res_first_q  <= ram_rdata[COLOUR_W-1:0];
				res_second_q <= ram_rdata[2*COLOUR_W-1:COLOUR_W];
			end
			default: ;
		endcase
	end

	// output register, freed when the downstream side takes the transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_first_q  <= res_first_q;
			out_second_q <= res_second_q;
			out_app_q    <= res_app_q;
			out_ref_q    <= res_ref_q;
		end
	end

	spq_colour_mod u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.divisor (divisor),
		.raw_a   (rand_a_q),
		.raw_b   (rand_b_q),
		.done    (mod_done),
		.rem_a   (rem_a),
		.rem_b   (rem_b)
	);

	spq_pair_ram #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata ({rem_b, rem_a}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign out_valid     = out_valid_q;
	assign first_colour  = out_first_q;
	assign second_colour = out_second_q;
	assign appended      = out_app_q;
	assign refused       = out_ref_q;

endmodule

@@ verif/shared_pair_queue_multi_reader_tb.sv @@
// self-checking testbench for the shared pair queue with per-player read offsets
`timescale 1ns / 1ps
module shared_pair_queue_multi_reader_tb;
	import spq_pkg::*;

	localparam int QDEPTH      = QUEUE_DEPTH_DEF;
	localparam int PLAYERS_MAX = MAX_PLAYERS_DEF;
	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLDOFF_LEN = 300;

	typedef struct packed {
		logic                op;
		logic [PLAYER_W-1:0] who;
		logic [RAND_W-1:0]   raw_first;
		logic [RAND_W-1:0]   raw_second;
	} pair_request_t;

	typedef struct packed {
		logic [COLOUR_W-1:0] first_col;
		logic [COLOUR_W-1:0] second_col;
		logic                was_appended;
		logic                was_refused;
	} pair_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_write = 1'b0;
	logic                cfg_index = REG_PLAYER_COUNT;
	logic [CFG_W-1:0]    cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                operation = OP_FETCH;
	logic [PLAYER_W-1:0] player = '0;
	logic [RAND_W-1:0]   random_first = '0;
	logic [RAND_W-1:0]   random_second = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [COLOUR_W-1:0] first_colour;
	logic [COLOUR_W-1:0] second_colour;
	logic                appended;
	logic                refused;

	shared_pair_queue_multi_reader u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.operation    (operation),
		.player       (player),
		.random_first (random_first),
		.random_second(random_second),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.first_colour (first_colour),
		.second_colour(second_colour),
		.appended     (appended),
		.refused      (refused)
	);

	// predictor state, mirrors the block
	logic [2*COLOUR_W-1:0] pair_mem [QDEPTH];
	int                    head_slot = 0;
	int                    held_pairs = 0;
	int                    read_offs [PLAYERS_MAX];
	logic [PCOUNT_W-1:0]   player_count_copy = PCOUNT_W'(2);
	logic [COLOUR_W-1:0]   colour_count_copy = COLOUR_W'(4);

	pair_request_t pending_requests [$];
	pair_result_t  expected_pairs [$];

	int  send_idle_pct = 0;
	int  recv_stall_pct = 0;
	int  holdoff_asked = 0;
	int  holdoff_done = 0;
	int  holdoff_left = 0;
	bit  accepted_now = 1'b0;
	int  cycle_count = 0;
	int  mismatch_count = 0;
	int  results_checked = 0;
	int  n_fetches = 0;
	int  n_appends = 0;
	int  n_refusals = 0;
	int  n_clears = 0;
	int  n_ignored = 0;

	initial begin
		foreach (read_offs[i]) read_offs[i] = 0;
		foreach (pair_mem[i]) pair_mem[i] = '0;
	end

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic int active_players();
		if (player_count_copy == 0) return 1;
		if (int'(player_count_copy) > PLAYERS_MAX) return PLAYERS_MAX;
		return int'(player_count_copy);
	endfunction

	function automatic pair_result_t serve_request(pair_request_t rq);
		pair_result_t res;
		int n;
		int colours;
		int off;
		int slot;
		int lowest;
		res = '0;
		n = active_players();
		if (rq.op == OP_CLEAR) begin
			foreach (read_offs[i]) read_offs[i] = 0;
			head_slot = 0;
			held_pairs = 0;
			n_clears++;
			return res;
		end
		if (int'(rq.who) >= n) begin
			n_ignored++;
			return res;
		end
		n_fetches++;
		off = read_offs[rq.who];
		if (off > held_pairs) off = held_pairs;
		if (off == held_pairs) begin
			if (held_pairs >= QDEPTH) begin
				res.was_refused = 1'b1;
				n_refusals++;
				return res;
			end
			colours = (colour_count_copy == 0) ? 1 :
				(colour_count_copy > COLOUR_MAX) ? int'(COLOUR_MAX) : int'(colour_count_copy);
			slot = (head_slot + held_pairs) % QDEPTH;
			pair_mem[slot] = {COLOUR_W'(int'(rq.raw_second) % colours),
				COLOUR_W'(int'(rq.raw_first) % colours)};
			held_pairs++;
			res.was_appended = 1'b1;
			n_appends++;
		end
		slot = (head_slot + off) % QDEPTH;
		res.first_col = pair_mem[slot][COLOUR_W-1:0];
		res.second_col = pair_mem[slot][2*COLOUR_W-1:COLOUR_W];
		read_offs[rq.who] = off + 1;
		// drop what every active player has already read
		lowest = read_offs[0];
		for (int i = 1; i < n; i++)
			if (read_offs[i] < lowest) lowest = read_offs[i];
		if (lowest > held_pairs) lowest = held_pairs;
		foreach (read_offs[i])
			read_offs[i] = (read_offs[i] > lowest) ? read_offs[i] - lowest : 0;
		head_slot = (head_slot + lowest) % QDEPTH;
		held_pairs -= lowest;
		return res;
	endfunction

	task automatic report_mismatch(string what, pair_result_t exp_r, pair_result_t got_r);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("[%0t] %s: expected first %0d second %0d app %0b ref %0b, got first %0d second %0d app %0b ref %0b",
				$time, what, exp_r.first_col, exp_r.second_col, exp_r.was_appended,
				exp_r.was_refused, got_r.first_col, got_r.second_col, got_r.was_appended,
				got_r.was_refused);
	endtask

	// input side: a transaction is taken here, predicted and retired from the pending queue
	always @(posedge clk) begin
		accepted_now = 1'b0;
		if (arst_n && in_valid && !in_stall) begin
			expected_pairs.insert(expected_pairs.size(), serve_request(pending_requests[0]));
			void'(pending_requests.pop_front());
			accepted_now = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !accepted_now) begin
				// stalled, payload holds
			end else if (pending_requests.size() != 0 &&
				$urandom_range(0, 99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				operation <= pending_requests[0].op;
				player <= pending_requests[0].who;
				random_first <= pending_requests[0].raw_first;
				random_second <= pending_requests[0].raw_second;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (holdoff_left != 0) begin
			holdoff_left <= holdoff_left - 1;
		end else if (holdoff_asked != holdoff_done) begin
			holdoff_left <= HOLDOFF_LEN;
			holdoff_done <= holdoff_done + 1;
		end
	end

	always @(negedge clk) begin
		out_stall <= (holdoff_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
	end

	// output side
	always @(posedge clk) begin
		pair_result_t got_r;
		pair_result_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			got_r = '{first_colour, second_colour, appended, refused};
			if (expected_pairs.size() == 0) begin
				report_mismatch("result with nothing expected", '0, got_r);
			end else begin
				exp_r = expected_pairs.pop_front();
				results_checked++;
				if (got_r.first_col !== exp_r.first_col || got_r.second_col !== exp_r.second_col ||
					got_r.was_appended !== exp_r.was_appended ||
					got_r.was_refused !== exp_r.was_refused)
					report_mismatch("result mismatch", exp_r, got_r);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_pairs.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic push_request(logic op, int who, int raw_a, int raw_b);
		pair_request_t rq;
		rq.op = op;
		rq.who = PLAYER_W'(who);
		rq.raw_first = RAND_W'(raw_a);
		rq.raw_second = RAND_W'(raw_b);
		pending_requests.insert(pending_requests.size(), rq);
	endtask

	task automatic wait_drained(int settle);
		while (pending_requests.size() != 0 || expected_pairs.size() != 0 || in_valid)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [CFG_W-1:0] value);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
		if (idx == REG_PLAYER_COUNT) player_count_copy = value;
		else colour_count_copy = value[COLOUR_W-1:0];
	endtask

	// mostly well-formed fetches, one player favoured per stretch so the queue can fill
	task automatic push_random(int count);
		int favoured;
		int pick;
		int n;
		favoured = 0;
		n = active_players();
		for (int k = 0; k < count; k++) begin
			if (k % 40 == 0) favoured = $urandom_range(0, PLAYERS_MAX - 1) % n;
			pick = $urandom_range(0, 99);
			if (pick < 3)
				push_request(OP_CLEAR, $urandom_range(0, 7), $urandom_range(0, 32767),
					$urandom_range(0, 32767));
			else if (pick < 10)
				push_request(OP_FETCH, $urandom_range(0, 7), $urandom_range(0, 32767),
					$urandom_range(0, 32767));
			else if (pick < 55)
				push_request(OP_FETCH, favoured, $urandom_range(0, 32767),
					$urandom_range(0, 32767));
			else
				push_request(OP_FETCH, $urandom_range(0, n - 1), $urandom_range(0, 32767),
					$urandom_range(0, 32767));
		end
	endtask

	initial begin
		int ph_players [6] = '{8, 1, 0, 15, 3, 5};
		int ph_colours [6] = '{6, 1, 7, 0, 5, 14};
		int ph_idle [6]    = '{0, 52, 0, 29, 0, 29};
		int ph_stall [6]   = '{0, 0, 52, 29, 0, 29};
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: reset settings, two players, four colours
		push_request(OP_CLEAR, 7, 32767, 32767);
		push_request(OP_FETCH, 0, 0, 32767);
		push_request(OP_FETCH, 1, 32767, 0);
		push_request(OP_FETCH, 7, 32767, 32767);
		push_request(OP_FETCH, 2, 0, 0);
		// player 0 runs ahead until the queue is full and refuses
		for (int k = 0; k < 16; k++)
			push_request(OP_FETCH, 0, (k % 3 == 0) ? 0 : (k % 3 == 1) ? 32767 :
				$urandom_range(0, 32767), (k % 3 == 1) ? 0 : $urandom_range(0, 32767));
		push_request(OP_FETCH, 0, 12345, 23456);
		push_request(OP_FETCH, 1, 0, 0);
		push_request(OP_CLEAR, 0, 0, 0);
		push_request(OP_FETCH, 0, $urandom_range(0, 32767), $urandom_range(0, 32767));
		wait_drained(4);

		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_PLAYER_COUNT, CFG_W'(ph_players[ph]));
			write_reg(REG_COLOUR_COUNT, CFG_W'(ph_colours[ph]));
			send_idle_pct = ph_idle[ph];
			recv_stall_pct = ph_stall[ph];
			if (ph == 4) begin
				push_random(120);
				// receiver holds off while requests keep coming
				holdoff_asked = holdoff_asked + 1;
				while (holdoff_done != holdoff_asked) @(posedge clk);
				while (holdoff_left != 0) @(posedge clk);
				// sender pauses until everything is back
				wait_drained(0);
				push_random(120);
			end else begin
				push_random(240);
			end
			wait_drained(4);
		end

		wait_drained(20);
		if (expected_pairs.size() != 0) mismatch_count += expected_pairs.size();
		$display("covered %0d fetches (%0d appends, %0d refusals), %0d clears, %0d ignored",
			n_fetches, n_appends, n_refusals, n_clears, n_ignored);
		$display("over six settings, %0d results checked in %0d cycles, %0d mismatches",
			results_checked, cycle_count, mismatch_count);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
